/* hw/rtl/bplru_pkg.sv */
package bplru_pkg;

	localparam int FRAMES    = 8;
	localparam int PAGE_BITS = 16;
	localparam int PIN_BITS  = 8;
	localparam int IDX_W     = $clog2(FRAMES);

	localparam logic [PIN_BITS-1:0] PIN_MAX  = {PIN_BITS{1'b1}};
	localparam logic [IDX_W-1:0]    RANK_TOP = IDX_W'(FRAMES - 1);

	typedef enum logic {
		OP_PIN   = 1'b0,
		OP_UNPIN = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_NOT_RES  = 3'd2,
		STAT_UNPINNED = 3'd3,
		STAT_SAT      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_UPD
	} state_t;

	// lookup results handed from cell to cell along the row
	typedef struct packed {
		logic                 has_match;
		logic [IDX_W-1:0]     match_idx;
		logic [PIN_BITS-1:0]  match_pin;
		logic [IDX_W-1:0]     match_rank;
		logic                 has_free;
		logic [IDX_W-1:0]     free_idx;
		logic [IDX_W-1:0]     free_rank;
		logic                 has_vic;
		logic [IDX_W-1:0]     vic_idx;
		logic [IDX_W-1:0]     vic_rank;
		logic [PAGE_BITS-1:0] vic_page;
		logic                 vic_dirty;
	} chain_t;

	// update command broadcast to every cell
	typedef struct packed {
		logic                 en;
		logic [IDX_W-1:0]     idx;
		logic                 write_pin;
		logic [PIN_BITS-1:0]  pin;
		logic                 load;
		logic [PAGE_BITS-1:0] page;
		logic                 or_dirty;
		logic                 mru;
		logic [IDX_W-1:0]     old_rank;
	} upd_t;

endpackage

/* hw/rtl/bplru_cell.sv */
module bplru_cell import bplru_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IDX_W-1:0]     self_idx,
	input  logic [PAGE_BITS-1:0] req_page,
	input  chain_t               chain_i,
	output chain_t               chain_o,
	input  upd_t                 upd
);

	logic                 valid_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [PIN_BITS-1:0]  pin_q;
	logic                 dirty_q;
	logic [IDX_W-1:0]     rank_q;

	logic sel;
	logic is_vic;

	assign sel    = upd.en && (upd.idx == self_idx);
	assign is_vic = valid_q && (pin_q == '0) &&
	                (!chain_i.has_vic || (rank_q < chain_i.vic_rank));

	// first match, first free frame, least recent unpinned frame so far
	always_comb begin
		chain_o = chain_i;
		if (!chain_i.has_match && valid_q && (page_q == req_page)) begin
			chain_o.has_match  = 1'b1;
			chain_o.match_idx  = self_idx;
			chain_o.match_pin  = pin_q;
			chain_o.match_rank = rank_q;
		end
		if (!chain_i.has_free && !valid_q) begin
			chain_o.has_free  = 1'b1;
			chain_o.free_idx  = self_idx;
			chain_o.free_rank = rank_q;
		end
		if (is_vic) begin
			chain_o.has_vic   = 1'b1;
			chain_o.vic_idx   = self_idx;
			chain_o.vic_rank  = rank_q;
			chain_o.vic_page  = page_q;
			chain_o.vic_dirty = dirty_q;
		end
	end

	// frame control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pin_q   <= '0;
			dirty_q <= 1'b0;
			rank_q  <= self_idx;
		end else begin
			if (upd.en && upd.mru) begin
				if (sel)
					rank_q <= RANK_TOP;
				else if (rank_q > upd.old_rank)
					rank_q <= rank_q - 1'b1;
			end
			if (sel && upd.write_pin)
				pin_q <= upd.pin;
			if (sel && upd.load) begin
				valid_q <= 1'b1;
				dirty_q <= 1'b0;
			end else if (sel && upd.or_dirty) begin
				dirty_q <= 1'b1;
			end
		end
	end

	// resident page, only read while valid
	always_ff @(posedge clk) begin
		if (sel && upd.load)
			page_q <= upd.page;
	end

endmodule

/* hw/rtl/buffer_pool_lru_pin_manager_unit.sv */
// Buffer pool frame manager with LRU replacement and pin counts. Each request
// (pin or unpin of a page) goes through a lookup state, in which the request
// ripples through the row of frame cells to find the matching frame, the lowest
// free frame and the least recent unpinned frame, and an update state, in which
// the chosen frame is written, recency ranks shift and the result word is loaded
// into the output register. A new request word is taken during the update state
// when the output register can accept, so a request is looked up only after the
// previous one is updated; the lookup ripple across all frames sets the clock period.
module buffer_pool_lru_pin_manager_unit import bplru_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 op,
	input  logic [PAGE_BITS-1:0] page_number,
	input  logic                 set_dirty,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic                 hit,
	output logic [IDX_W-1:0]     frame_index,
	output logic [2:0]           status,
	output logic                 evicted,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic                 write_back,
	output logic [PIN_BITS-1:0]  pin_level
);

	state_t state_q, state_d;

	logic                 req_op_q;
	logic [PAGE_BITS-1:0] req_page_q;
	logic                 req_dirty_q;
	chain_t               lk_q;
	chain_t               chain [FRAMES+1];
	upd_t                 upd;

	logic                 rsp_valid_q;
	logic                 hit_q, evicted_q, write_back_q;
	logic [IDX_W-1:0]     frame_index_q;
	logic [2:0]           status_q;
	logic [PAGE_BITS-1:0] evicted_page_q;
	logic [PIN_BITS-1:0]  pin_level_q;

	logic                 out_ready;
	logic                 fire;
	logic                 accept;
	logic                 r_hit, r_evicted, r_wb;
	logic [IDX_W-1:0]     r_idx;
	status_t              r_status;
	logic [PAGE_BITS-1:0] r_evpage;
	logic [PIN_BITS-1:0]  r_level;
	upd_t                 u;

	assign out_ready = !rsp_valid_q || !rsp_stall;
	assign accept    = req_valid && !req_stall;

	// row of frame cells
	assign chain[0] = '0;
	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		bplru_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.self_idx (IDX_W'(i)),
			.req_page (req_page_q),
			.chain_i  (chain[i]),
			.chain_o  (chain[i+1]),
			.upd      (upd)
		);
	end

	// decision from the registered lookup
	always_comb begin
		r_hit     = 1'b0;
		r_idx     = '0;
		r_status  = STAT_OK;
		r_evicted = 1'b0;
		r_evpage  = '0;
		r_wb      = 1'b0;
		r_level   = '0;
		u         = '0;
		u.page    = req_page_q;
		if (req_op_q == OP_PIN) begin
			if (lk_q.has_match) begin
				r_hit      = 1'b1;
				r_idx      = lk_q.match_idx;
				u.idx      = lk_q.match_idx;
				u.mru      = 1'b1;
				u.old_rank = lk_q.match_rank;
				if (lk_q.match_pin == PIN_MAX) begin
					r_status = STAT_SAT;
					r_level  = lk_q.match_pin;
				end else begin
					u.write_pin = 1'b1;
					u.pin       = lk_q.match_pin + 1'b1;
					r_level     = u.pin;
				end
			end else if (lk_q.has_free || lk_q.has_vic) begin
				u.load      = 1'b1;
				u.mru       = 1'b1;
				u.write_pin = 1'b1;
				u.pin       = PIN_BITS'(1);
				r_level     = PIN_BITS'(1);
				if (lk_q.has_free) begin
					u.idx      = lk_q.free_idx;
					u.old_rank = lk_q.free_rank;
				end else begin
					u.idx      = lk_q.vic_idx;
					u.old_rank = lk_q.vic_rank;
					r_evicted  = 1'b1;
					r_evpage   = lk_q.vic_page;
					r_wb       = lk_q.vic_dirty;
				end
				r_idx = u.idx;
			end else begin
				r_status = STAT_FULL;
			end
		end else begin
			if (!lk_q.has_match) begin
				r_status = STAT_NOT_RES;
			end else begin
				r_hit = 1'b1;
				r_idx = lk_q.match_idx;
				u.idx = lk_q.match_idx;
				if (lk_q.match_pin == '0) begin
					r_status = STAT_UNPINNED;
				end else begin
					u.write_pin = 1'b1;
					u.pin       = lk_q.match_pin - 1'b1;
					u.or_dirty  = req_dirty_q;
					r_level     = u.pin;
				end
			end
		end
	end

	// sequencer: idle, lookup, update
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		fire      = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid)
					state_d = S_LOOK;
			end
			S_LOOK: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				req_stall = !out_ready;
				if (out_ready) begin
					fire    = 1'b1;
					state_d = req_valid ? S_LOOK : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		upd    = u;
		upd.en = fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// request word and lookup registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_op_q    <= op;
			req_page_q  <= page_number;
			req_dirty_q <= set_dirty;
		end
		if (state_q == S_LOOK)
			lk_q <= chain[FRAMES];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (fire)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_q          <= r_hit;
			frame_index_q  <= r_idx;
			status_q       <= r_status;
			evicted_q      <= r_evicted;
			evicted_page_q <= r_evpage;
			write_back_q   <= r_wb;
			pin_level_q    <= r_level;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign hit          = hit_q;
	assign frame_index  = frame_index_q;
	assign status       = status_q;
	assign evicted      = evicted_q;
	assign evicted_page = evicted_page_q;
	assign write_back   = write_back_q;
	assign pin_level    = pin_level_q;

endmodule

/* hw/rtl/bplru_checker.sv */
module bplru_checker import bplru_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_stall,
	input logic                 hit,
	input logic [IDX_W-1:0]     frame_index,
	input logic [2:0]           status,
	input logic                 evicted,
	input logic [PAGE_BITS-1:0] evicted_page,
	input logic                 write_back,
	input logic [PIN_BITS-1:0]  pin_level
);

	// a stalled result word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result word dropped while stalled");

	// failed lookups report no frame
	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STAT_FULL || status == STAT_NOT_RES) |->
		!hit && frame_index == '0 && pin_level == '0 && !evicted)
		else $error("pool full or not resident carries frame data");

	// eviction fields are clean unless a page was replaced
	a_evict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !evicted |-> evicted_page == '0 && !write_back)
		else $error("eviction fields set without eviction");

	// an eviction is always a fresh load with one pin
	a_evict_load: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && evicted |-> !hit && status == STAT_OK && pin_level == PIN_BITS'(1))
		else $error("eviction without a fresh load");

	// saturation only on a hit at the pin ceiling
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_SAT |-> hit && pin_level == PIN_MAX)
		else $error("pin saturated reported below ceiling");

endmodule

bind buffer_pool_lru_pin_manager_unit bplru_checker u_bplru_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.hit          (hit),
	.frame_index  (frame_index),
	.status       (status),
	.evicted      (evicted),
	.evicted_page (evicted_page),
	.write_back   (write_back),
	.pin_level    (pin_level)
);
